### hw/rtl/longest_increasing_subsequence_length_macros.svh
// Assertion macros shared by the longest increasing subsequence RTL.
// Depends on clk_i and rst_ni being in scope where a macro is used.
`ifndef LONGEST_INCREASING_SUBSEQUENCE_LENGTH_MACROS_SVH
`define LONGEST_INCREASING_SUBSEQUENCE_LENGTH_MACROS_SVH
`ifndef NO_ASSERTIONS
// Check a property on every clock edge outside reset.
`define LISL_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("lisl: assertion failed");
// Check that a condition is followed by a consequence in the next cycle.
`define LISL_ASSERT_NEXT(lbl, cond, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond) |=> (cons)) \
    else $error("lisl: assertion failed");
`else
`define LISL_ASSERT(lbl, prop)
`define LISL_ASSERT_NEXT(lbl, cond, cons)
`endif
`endif

### hw/rtl/lisl_pkg.sv
// Package for the longest increasing subsequence block: sizes, words and
// the command and status groups between controller and datapath. No dependencies.
`default_nettype none
package lisl_pkg;

  localparam int unsigned DEPTH       = 64;
  localparam int unsigned VALUE_WIDTH = 16;
  localparam int unsigned LEN_WIDTH   = 7;
  localparam int unsigned ADDR_WIDTH  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_WIDTH   = $clog2(DEPTH + 1);
  localparam int unsigned ENTRY_WIDTH = VALUE_WIDTH + CNT_WIDTH;

  typedef struct packed {
    logic signed [VALUE_WIDTH-1:0] value;
    logic                          last;
  } in_word_t;

  typedef struct packed {
    logic [LEN_WIDTH-1:0] length_ending_here;
    logic [LEN_WIDTH-1:0] best_length;
    logic                 end_of_sequence;
    logic                 overflow;
  } out_word_t;

  typedef struct packed {
    logic start;
    logic scan;
    logic commit;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
    logic last_issue;
    logic out_busy;
  } sts_t;

endpackage
`default_nettype wire

### hw/rtl/lisl_in_if.sv
// Input channel: valid, ready and one input word.
// Depends on lisl_pkg.
`default_nettype none
interface lisl_in_if;
  import lisl_pkg::*;

  logic     valid;
  logic     ready;
  in_word_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

### hw/rtl/lisl_out_if.sv
// Output channel: valid, ready and one result word.
// Depends on lisl_pkg.
`default_nettype none
interface lisl_out_if;
  import lisl_pkg::*;

  logic      valid;
  logic      ready;
  out_word_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

### hw/rtl/longest_increasing_subsequence_length.sv
// Longest strictly increasing subsequence length, streamed one element per word.
//
// Channels: in_i (sink) carries value and last; out_o (source) carries
// length_ending_here, best_length, end_of_sequence and overflow. A word
// moves at a rising edge where valid and ready are both high.
// Each input word produces exactly one output word, in order.
// Per element, the datapath reads every stored entry of the current
// sequence from the single-read-port store, one per cycle. With N entries
// stored, the result is registered at commit, after the scan and a drain
// state, and the next input word is taken only after commit (scan and
// drain are skipped with an empty or full store). The store's one read
// port sets the rate of elements.
// The result sits in an output register: while the receiver stalls the
// scan of the next element goes on and the block waits only at commit.
// Reset (rst_ni low, asynchronous) clears the element count, running best
// and output valid; the store needs no clearing since only entries written
// in the current sequence are read. A word with last set ends the sequence.
`default_nettype none
module longest_increasing_subsequence_length (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  lisl_in_if.sink   in_i,
  lisl_out_if.source out_o
);
  import lisl_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // sequencing: accept, scan, drain the read pipeline, commit
  lisl_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // store, compare stage, counters and the output register
  lisl_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_word_i   (in_i.data),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_ready_i (out_o.ready),
    .out_valid_o (out_o.valid),
    .out_word_o  (out_o.data)
  );

endmodule
`default_nettype wire

### hw/rtl/lisl_ram.sv
// Generic RAM: one write port, one read port with registered read data.
// No dependencies.
`default_nettype none
module lisl_ram #(
  parameter int unsigned Width     = 8,
  parameter int unsigned Depth     = 2,
  parameter int unsigned AddrWidth = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  wire logic                 clk_i,
  input  wire logic                 we_i,
  input  wire logic [AddrWidth-1:0] waddr_i,
  input  wire logic [Width-1:0]     wdata_i,
  input  wire logic                 re_i,
  input  wire logic [AddrWidth-1:0] raddr_i,
  output logic      [Width-1:0]     rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule
`default_nettype wire

### hw/rtl/lisl_ctrl.sv
// Controller state machine: accept, scan the store, drain, commit.
// Depends on lisl_pkg and the assertion macro header.
`default_nettype none
`include "longest_increasing_subsequence_length_macros.svh"
module lisl_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  input  wire lisl_pkg::sts_t sts_i,
  output lisl_pkg::cmd_t     cmd_o
);
  import lisl_pkg::*;

  typedef enum logic [3:0] {
    StIdle  = 4'b0001,
    StScan  = 4'b0010,
    StDrain = 4'b0100,
    StDone  = 4'b1000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      StIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.start = 1'b1;
          // skip the scan when nothing is stored or the store is full
          if (sts_i.full || sts_i.empty) begin
            state_d = StDone;
          end else begin
            state_d = StScan;
          end
        end
      end
      StScan: begin
        cmd_o.scan = 1'b1;
        if (sts_i.last_issue) begin
          state_d = StDrain;
        end
      end
      StDrain: begin
        // last read word lands in the compare stage here
        state_d = StDone;
      end
      StDone: begin
        if (!sts_i.out_busy) begin
          cmd_o.commit = 1'b1;
          state_d      = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  `LISL_ASSERT(a_scan_needs_entries, (state_q == StScan) |-> (!sts_i.empty && !sts_i.full))

endmodule
`default_nettype wire

### hw/rtl/lisl_dp.sv
// Datapath: element store, scan compare, counters and the result register.
// Depends on lisl_pkg, lisl_ram and the assertion macro header.
`default_nettype none
`include "longest_increasing_subsequence_length_macros.svh"
module lisl_dp (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire lisl_pkg::in_word_t in_word_i,
  input  wire lisl_pkg::cmd_t     cmd_i,
  output lisl_pkg::sts_t          sts_o,
  input  wire logic               out_ready_i,
  output logic                    out_valid_o,
  output lisl_pkg::out_word_t     out_word_o
);
  import lisl_pkg::*;

  logic [CNT_WIDTH-1:0]          cnt_q, best_q, new_best;
  logic [CNT_WIDTH-1:0]          idx_q, len_q, rd_len, cand_len;
  logic signed [VALUE_WIDTH-1:0] value_q, rd_value;
  logic                          last_q, ovf_q, rd_vld_q, out_valid_q, extend;
  logic [ENTRY_WIDTH-1:0]        ram_rdata;
  out_word_t                     out_word_q;

  lisl_ram #(
    .Width(ENTRY_WIDTH),
    .Depth(DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (cmd_i.commit && !ovf_q),
    .waddr_i (cnt_q[ADDR_WIDTH-1:0]),
    .wdata_i ({value_q, len_q}),
    .re_i    (cmd_i.scan),
    .raddr_i (idx_q[ADDR_WIDTH-1:0]),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    rd_value = ram_rdata[ENTRY_WIDTH-1 -: VALUE_WIDTH];
    rd_len   = ram_rdata[CNT_WIDTH-1:0];
    cand_len = rd_len + CNT_WIDTH'(1);
    // strict increase only: an equal earlier value does not extend
    extend   = rd_vld_q && (value_q > rd_value) && (cand_len > len_q);
    new_best = (!ovf_q && (len_q > best_q)) ? len_q : best_q;
  end

  assign sts_o.full       = (cnt_q == CNT_WIDTH'(DEPTH));
  assign sts_o.empty      = (cnt_q == '0);
  assign sts_o.last_issue = ((idx_q + CNT_WIDTH'(1)) == cnt_q);
  assign sts_o.out_busy   = out_valid_q && !out_ready_i;
  assign out_valid_o      = out_valid_q;
  assign out_word_o       = out_word_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      best_q      <= '0;
      rd_vld_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      rd_vld_q <= cmd_i.scan;
      if (cmd_i.commit) begin
        out_valid_q <= 1'b1;
        if (last_q) begin
          cnt_q  <= '0;
          best_q <= '0;
        end else begin
          best_q <= new_best;
          if (!ovf_q) begin
            cnt_q <= cnt_q + CNT_WIDTH'(1);
          end
        end
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      value_q <= in_word_i.value;
      last_q  <= in_word_i.last;
      ovf_q   <= sts_o.full;
      len_q   <= CNT_WIDTH'(1);
      idx_q   <= '0;
    end
    if (cmd_i.scan) begin
      idx_q <= idx_q + CNT_WIDTH'(1);
    end
    if (extend) begin
      len_q <= cand_len;
    end
    if (cmd_i.commit) begin
      out_word_q.length_ending_here <= ovf_q ? '0 : LEN_WIDTH'(len_q);
      out_word_q.best_length        <= LEN_WIDTH'(new_best);
      out_word_q.end_of_sequence    <= last_q;
      out_word_q.overflow           <= ovf_q;
    end
  end

  `LISL_ASSERT(a_count_bounded, cnt_q <= CNT_WIDTH'(DEPTH))
  `LISL_ASSERT_NEXT(a_commit_shows, cmd_i.commit, out_valid_q)
  `LISL_ASSERT_NEXT(a_overflow_zero, cmd_i.commit && ovf_q, out_word_q.overflow && (out_word_q.length_ending_here == '0))

endmodule
`default_nettype wire
